// ----- hdl/plads_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plads_pkg
// Shared types and constants for the packed list add/delete/search unit.
// ----------------------------------------------------------------------------
package plads_pkg;

  localparam int VAL_W = 48;
  localparam int POS_W = 6;
  localparam int CNT_W = 7;
  localparam int REQ_W = 2;
  localparam int ST_W  = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_DUMP   = 2'd3
  } req_t;

  typedef enum logic [ST_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELETED   = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_DUMP      = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_DUMP_RD,
    S_DUMP_OUT,
    S_RESP
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic    take_req;   // latch key, restart walk
    logic    scan;       // issue next read of the walk
    logic    hit_jump;   // record match, aim walk past it
    logic    shift_wr;   // write previous read one place down
    logic    dump_rd;    // read entry at walk index
    logic    out_load;   // load output register
    status_t out_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_zero;
    logic full;
    logic more;       // walk index below count
    logic pvld;       // read data in flight
    logic hit;
    logic dump_last;
    logic out_free;
  } sts_t;

endpackage

// ----- hdl/plads_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plads_in_if
// Request channel: request type and key, valid/ready handshake.
// ----------------------------------------------------------------------------
interface plads_in_if;
  logic                         valid;
  logic                         ready;
  logic [plads_pkg::REQ_W-1:0]  req_type;
  logic [plads_pkg::VAL_W-1:0]  key_value;

  modport source (output valid, output req_type, output key_value, input ready);
  modport sink   (input valid, input req_type, input key_value, output ready);
endinterface

// ----- hdl/plads_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plads_out_if
// Result channel: status, entry, position, count and last marker.
// ----------------------------------------------------------------------------
interface plads_out_if;
  logic                         valid;
  logic                         ready;
  logic [plads_pkg::ST_W-1:0]   status;
  logic [plads_pkg::VAL_W-1:0]  entry_value;
  logic [plads_pkg::POS_W-1:0]  position;
  logic [plads_pkg::CNT_W-1:0]  entry_count;
  logic                         last;

  modport source (output valid, output status, output entry_value, output position,
                  output entry_count, output last, input ready);
  modport sink   (input valid, input status, input entry_value, input position,
                  input entry_count, input last, output ready);
endinterface

// ----- hdl/plads_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plads_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module plads_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/plads_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plads_ctrl
// Request sequencer: accepts a request, steps the datapath through the
// walk, shift or dump, and loads each result word.
// ----------------------------------------------------------------------------
module plads_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic [plads_pkg::REQ_W-1:0] in_req_type,
  output logic                        in_ready,
  input  plads_pkg::sts_t             sts,
  output plads_pkg::cmd_t             cmd
);

  plads_pkg::state_t  state_r, state_nxt;
  plads_pkg::status_t rsp_r, rsp_nxt;
  logic               del_r, del_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= plads_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    rsp_r <= rsp_nxt;
    del_r <= del_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    rsp_nxt        = rsp_r;
    del_nxt        = del_r;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.out_status = plads_pkg::ST_ADDED;
    unique case (state_r)
      plads_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_req = 1'b1;
          unique case (plads_pkg::req_t'(in_req_type))
            plads_pkg::REQ_APPEND: begin
              rsp_nxt   = sts.full ? plads_pkg::ST_FULL : plads_pkg::ST_ADDED;
              state_nxt = plads_pkg::S_RESP;
            end
            plads_pkg::REQ_DELETE: begin
              del_nxt   = 1'b1;
              state_nxt = plads_pkg::S_SCAN;
            end
            plads_pkg::REQ_SEARCH: begin
              del_nxt   = 1'b0;
              state_nxt = plads_pkg::S_SCAN;
            end
            plads_pkg::REQ_DUMP: begin
              if (sts.cnt_zero) begin
                rsp_nxt   = plads_pkg::ST_EMPTY;
                state_nxt = plads_pkg::S_RESP;
              end else begin
                state_nxt = plads_pkg::S_DUMP_RD;
              end
            end
            default: ;
          endcase
        end
      end
      plads_pkg::S_SCAN: begin
        if (sts.hit) begin
          cmd.hit_jump = 1'b1;
          if (del_r) begin
            state_nxt = plads_pkg::S_SHIFT;
          end else begin
            rsp_nxt   = plads_pkg::ST_FOUND;
            state_nxt = plads_pkg::S_RESP;
          end
        end else if (!sts.more && !sts.pvld) begin
          rsp_nxt   = plads_pkg::ST_NOT_FOUND;
          state_nxt = plads_pkg::S_RESP;
        end else begin
          cmd.scan = 1'b1;
        end
      end
      plads_pkg::S_SHIFT: begin
        cmd.scan     = 1'b1;
        cmd.shift_wr = 1'b1;
        if (!sts.more && !sts.pvld) begin
          rsp_nxt   = plads_pkg::ST_DELETED;
          state_nxt = plads_pkg::S_RESP;
        end
      end
      plads_pkg::S_DUMP_RD: begin
        cmd.dump_rd = 1'b1;
        state_nxt   = plads_pkg::S_DUMP_OUT;
      end
      plads_pkg::S_DUMP_OUT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = plads_pkg::ST_DUMP;
          state_nxt      = sts.dump_last ? plads_pkg::S_IDLE : plads_pkg::S_DUMP_RD;
        end
      end
      plads_pkg::S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = rsp_r;
          state_nxt      = plads_pkg::S_IDLE;
        end
      end
      default: state_nxt = plads_pkg::S_IDLE;
    endcase
  end

endmodule

// ----- hdl/plads_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plads_dp
// Datapath: key list RAM, count, walk index with one-deep read pipeline,
// key compare and the output register.
// ----------------------------------------------------------------------------
module plads_dp #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 48
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  plads_pkg::cmd_t             cmd,
  output plads_pkg::sts_t             sts,
  input  logic [plads_pkg::VAL_W-1:0] in_key,
  plads_out_if.source                 out_ch
);

  localparam int KW = (KEY_WIDTH < plads_pkg::VAL_W) ? KEY_WIDTH : plads_pkg::VAL_W;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [KW-1:0] key_r, key_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] pidx_r, pidx_nxt;
  logic          pvld_r, pvld_nxt;
  logic [AW-1:0] pos_r, pos_nxt;

  plads_pkg::status_t          ost_r, ost_nxt;
  logic [plads_pkg::VAL_W-1:0] oval_r, oval_nxt;
  logic [plads_pkg::POS_W-1:0] opos_r, opos_nxt;
  logic [plads_pkg::CNT_W-1:0] ocnt_r, ocnt_nxt;
  logic                        olast_r, olast_nxt;
  logic                        ov_r, ov_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [KW-1:0] ram_wdata, ram_rdata;

  logic more, dump_last, out_free;

  plads_ram #(.WIDTH(KW), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign more      = idx_r < cnt_r;
  assign dump_last = (idx_r + CW'(1)) == cnt_r;
  assign out_free  = !ov_r || out_ch.ready;

  assign sts.cnt_zero  = cnt_r == '0;
  assign sts.full      = cnt_r == CW'(DEPTH);
  assign sts.more      = more;
  assign sts.pvld      = pvld_r;
  assign sts.hit       = pvld_r && (ram_rdata == key_r);
  assign sts.dump_last = dump_last;
  assign sts.out_free  = out_free;

  always_comb begin
    key_nxt   = key_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    pidx_nxt  = pidx_r;
    pvld_nxt  = pvld_r;
    pos_nxt   = pos_r;
    ost_nxt   = ost_r;
    oval_nxt  = oval_r;
    opos_nxt  = opos_r;
    ocnt_nxt  = ocnt_r;
    olast_nxt = olast_r;
    ov_nxt    = ov_r;

    ram_re    = (cmd.scan && more) || cmd.dump_rd;
    ram_raddr = idx_r[AW-1:0];
    ram_we    = cmd.shift_wr && pvld_r;
    ram_waddr = pidx_r - AW'(1);
    ram_wdata = ram_rdata;

    if (cmd.take_req) begin
      key_nxt  = in_key[KW-1:0];
      idx_nxt  = '0;
      pvld_nxt = 1'b0;
    end

    if (cmd.scan) begin
      if (more) begin
        idx_nxt  = idx_r + CW'(1);
        pidx_nxt = idx_r[AW-1:0];
        pvld_nxt = 1'b1;
      end else begin
        pvld_nxt = 1'b0;
      end
    end

    if (cmd.hit_jump) begin
      pos_nxt  = pidx_r;
      idx_nxt  = CW'(pidx_r) + CW'(1);
      pvld_nxt = 1'b0;
    end

    if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    if (cmd.out_load) begin
      ov_nxt    = 1'b1;
      ost_nxt   = cmd.out_status;
      oval_nxt  = '0;
      opos_nxt  = '0;
      olast_nxt = 1'b1;
      unique case (cmd.out_status)
        plads_pkg::ST_ADDED: begin
          opos_nxt  = plads_pkg::POS_W'(cnt_r[AW-1:0]);
          cnt_nxt   = cnt_r + CW'(1);
          ram_we    = 1'b1;
          ram_waddr = cnt_r[AW-1:0];
          ram_wdata = key_r;
        end
        plads_pkg::ST_DELETED: begin
          opos_nxt = plads_pkg::POS_W'(pos_r);
          cnt_nxt  = cnt_r - CW'(1);
        end
        plads_pkg::ST_FOUND: begin
          opos_nxt = plads_pkg::POS_W'(pos_r);
        end
        plads_pkg::ST_DUMP: begin
          oval_nxt  = plads_pkg::VAL_W'(ram_rdata);
          opos_nxt  = plads_pkg::POS_W'(idx_r[AW-1:0]);
          olast_nxt = dump_last;
          idx_nxt   = idx_r + CW'(1);
        end
        default: ;
      endcase
      ocnt_nxt = plads_pkg::CNT_W'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pvld_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      pvld_r <= pvld_nxt;
      ov_r   <= ov_nxt;
    end
    key_r   <= key_nxt;
    idx_r   <= idx_nxt;
    pidx_r  <= pidx_nxt;
    pos_r   <= pos_nxt;
    ost_r   <= ost_nxt;
    oval_r  <= oval_nxt;
    opos_r  <= opos_nxt;
    ocnt_r  <= ocnt_nxt;
    olast_r <= olast_nxt;
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.status      = ost_r;
  assign out_ch.entry_value = oval_r;
  assign out_ch.position    = opos_r;
  assign out_ch.entry_count = ocnt_r;
  assign out_ch.last        = olast_r;

endmodule

// ----- hdl/packed_list_add_delete_search_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_list_add_delete_search_unit
// Packed key list with append, delete, search and dump requests.
//
// in_ch carries one request word (req_type, key_value); out_ch returns
// result words (status, entry_value, position, entry_count, last). Keys are
// masked to KEY_WIDTH bits. Every request gives one word with last set,
// except a dump of a non-empty list, which gives one word per entry in
// order with last on the final one.
// One request is worked at a time; in_ch.ready is high only while idle.
// Append and empty dump load their result word directly; search walks
// the list to the match; delete walks to the match, then shifts the tail
// down one entry per cycle; dump reads each entry and then loads its
// word, one entry at a time. This pace is set by the single read port
// of the key RAM and its registered read.
// The output register frees the sequencer once the final word is loaded,
// so a new request is taken while that word still waits; a stalled
// receiver holds the pending word and pauses the sequencer otherwise.
// Reset (rst_n low, synchronous) empties the list and drops any pending
// word; no clearing pass over the RAM is needed.
// ----------------------------------------------------------------------------
module packed_list_add_delete_search_unit #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 48
) (
  input  logic       clk,
  input  logic       rst_n,
  plads_in_if.sink   in_ch,
  plads_out_if.source out_ch
);

  plads_pkg::cmd_t cmd;
  plads_pkg::sts_t sts;
  logic            in_ready;

  plads_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  plads_dp #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .sts    (sts),
    .in_key (in_ch.key_value),
    .out_ch (out_ch)
  );

  assign in_ch.ready = in_ready;

  a_not_last_is_dump: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.last |-> out_ch.status == plads_pkg::ST_DUMP)
    else $error("non-final word outside a dump");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.entry_count <= plads_pkg::CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request taken while busy");

  a_single_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free && !cmd.take_req)
    else $error("output load without free slot");

endmodule

// ----- dv/packed_list_add_delete_search_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packed_list_add_delete_search_unit_tb
// Self-checking bench for the packed key list unit.
//
// Drives requests (append, delete, search, dump) on the request channel.
// A behavioral copy of the list works out the result words for each
// accepted request, and every result word is compared field by field in
// order. A short directed table covers the empty list, extreme keys,
// duplicates and shifting on delete. Random bursts follow: mixed traffic,
// fills to a full list with overflow appends, and drains back to empty.
// Both channels idle at random, and the receiver blocks for one long
// stretch so that the unit backs up into its request channel.
// ----------------------------------------------------------------------------
module packed_list_add_delete_search_unit_tb;

  localparam int DEPTH           = 64;
  localparam int KEY_WIDTH       = 48;
  localparam int RANDOM_REQUESTS = 300;
  localparam int HOLD_CYCLES     = 300;
  localparam int IDLE_LIMIT      = 4000;
  localparam int TAIL_CYCLES     = 3 * DEPTH + 20;
  localparam int NUM_DIRECTED    = 23;

  localparam logic [63:0] KEY_MASK64 =
    (KEY_WIDTH >= 64) ? '1 : ((64'd1 << KEY_WIDTH) - 64'd1);
  localparam logic [plads_pkg::VAL_W-1:0] KEY_MASK = KEY_MASK64[plads_pkg::VAL_W-1:0];
  localparam logic [plads_pkg::VAL_W-1:0] ALL1 = '1;
  localparam logic [plads_pkg::VAL_W-1:0] K5 = 48'h5555_5555_5555;
  localparam logic [plads_pkg::VAL_W-1:0] KA = 48'hAAAA_AAAA_AAAA;

  typedef struct packed {
    plads_pkg::status_t            status;
    logic [plads_pkg::VAL_W-1:0]   value;
    logic [plads_pkg::POS_W-1:0]   pos;
    logic [plads_pkg::CNT_W-1:0]   cnt;
    logic                          last;
  } list_word_t;

  typedef struct {
    plads_pkg::req_t             kind;
    logic [plads_pkg::VAL_W-1:0] key;
    bit                          typed;
    plads_pkg::status_t          status;
    logic [plads_pkg::POS_W-1:0] pos;
    logic [plads_pkg::CNT_W-1:0] cnt;
  } dir_row_t;

  dir_row_t directed_rows [NUM_DIRECTED] = '{
    '{plads_pkg::REQ_DUMP,   '0,   1'b1, plads_pkg::ST_EMPTY,     6'd0, 7'd0},
    '{plads_pkg::REQ_SEARCH, '0,   1'b1, plads_pkg::ST_NOT_FOUND, 6'd0, 7'd0},
    '{plads_pkg::REQ_DELETE, ALL1, 1'b1, plads_pkg::ST_NOT_FOUND, 6'd0, 7'd0},
    '{plads_pkg::REQ_APPEND, '0,   1'b1, plads_pkg::ST_ADDED,     6'd0, 7'd1},
    '{plads_pkg::REQ_APPEND, ALL1, 1'b1, plads_pkg::ST_ADDED,     6'd1, 7'd2},
    '{plads_pkg::REQ_APPEND, K5,   1'b1, plads_pkg::ST_ADDED,     6'd2, 7'd3},
    '{plads_pkg::REQ_APPEND, '0,   1'b1, plads_pkg::ST_ADDED,     6'd3, 7'd4},
    '{plads_pkg::REQ_SEARCH, '0,   1'b0, plads_pkg::ST_FOUND,     6'd0, 7'd0},
    '{plads_pkg::REQ_SEARCH, ALL1, 1'b0, plads_pkg::ST_FOUND,     6'd0, 7'd0},
    '{plads_pkg::REQ_SEARCH, KA,   1'b0, plads_pkg::ST_FOUND,     6'd0, 7'd0},
    '{plads_pkg::REQ_DUMP,   KA,   1'b0, plads_pkg::ST_FOUND,     6'd0, 7'd0},
    '{plads_pkg::REQ_DELETE, '0,   1'b0, plads_pkg::ST_FOUND,     6'd0, 7'd0},
    '{plads_pkg::REQ_SEARCH, '0,   1'b0, plads_pkg::ST_FOUND,     6'd0, 7'd0},
    '{plads_pkg::REQ_DELETE, ALL1, 1'b0, plads_pkg::ST_FOUND,     6'd0, 7'd0},
    '{plads_pkg::REQ_DELETE, KA,   1'b0, plads_pkg::ST_FOUND,     6'd0, 7'd0},
    '{plads_pkg::REQ_DUMP,   '0,   1'b0, plads_pkg::ST_FOUND,     6'd0, 7'd0},
    '{plads_pkg::REQ_DELETE, K5,   1'b0, plads_pkg::ST_FOUND,     6'd0, 7'd0},
    '{plads_pkg::REQ_DELETE, '0,   1'b0, plads_pkg::ST_FOUND,     6'd0, 7'd0},
    '{plads_pkg::REQ_DUMP,   ALL1, 1'b1, plads_pkg::ST_EMPTY,     6'd0, 7'd0},
    '{plads_pkg::REQ_APPEND, KA,   1'b1, plads_pkg::ST_ADDED,     6'd0, 7'd1},
    '{plads_pkg::REQ_SEARCH, KA,   1'b0, plads_pkg::ST_FOUND,     6'd0, 7'd0},
    '{plads_pkg::REQ_DELETE, KA,   1'b0, plads_pkg::ST_FOUND,     6'd0, 7'd0},
    '{plads_pkg::REQ_APPEND, 48'h1, 1'b0, plads_pkg::ST_FOUND,    6'd0, 7'd0}
  };

  logic clk;
  logic rst_n;

  plads_in_if  in_ch ();
  plads_out_if out_ch ();

  packed_list_add_delete_search_unit #(
    .DEPTH     (DEPTH),
    .KEY_WIDTH (KEY_WIDTH)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow list
  logic [plads_pkg::VAL_W-1:0] list_keys [DEPTH];
  int               list_len;
  int               list_peak;
  list_word_t       model_words [$];
  list_word_t       pending_words [$];
  list_word_t       want;

  int  mismatches;
  int  words_checked;
  int  requests_sent;
  int  dumps_sent;
  int  full_hits;
  int  fills;
  int  in_accepts;
  int  idle_cycles;
  bit  steady;
  bit  hold_off;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report(input string msg);
    mismatches++;
    $display("%0t ERROR %s", $time, msg);
  endtask

  task automatic model_request(input plads_pkg::req_t kind,
                               input logic [plads_pkg::VAL_W-1:0] key_in);
    logic [plads_pkg::VAL_W-1:0] key;
    list_word_t       w;
    int               hit;
    int               i;
    key = key_in & KEY_MASK;
    hit = -1;
    model_words.delete();
    w = '{status: plads_pkg::ST_ADDED, value: '0, pos: '0, cnt: '0, last: 1'b1};
    for (i = 0; i < list_len; i++)
      if (hit < 0 && list_keys[i] == key) hit = i;
    case (kind)
      plads_pkg::REQ_APPEND: begin
        if (list_len < DEPTH) begin
          list_keys[list_len] = key;
          w.pos = plads_pkg::POS_W'(list_len);
          list_len++;
        end else begin
          w.status = plads_pkg::ST_FULL;
          full_hits++;
        end
        w.cnt = plads_pkg::CNT_W'(list_len);
        model_words.push_back(w);
      end
      plads_pkg::REQ_DELETE: begin
        if (hit >= 0) begin
          for (i = hit; i + 1 < list_len; i++) list_keys[i] = list_keys[i + 1];
          list_len--;
          w.status = plads_pkg::ST_DELETED;
          w.pos    = plads_pkg::POS_W'(hit);
        end else begin
          w.status = plads_pkg::ST_NOT_FOUND;
        end
        w.cnt = plads_pkg::CNT_W'(list_len);
        model_words.push_back(w);
      end
      plads_pkg::REQ_SEARCH: begin
        w.status = (hit >= 0) ? plads_pkg::ST_FOUND : plads_pkg::ST_NOT_FOUND;
        w.pos    = (hit >= 0) ? plads_pkg::POS_W'(hit) : '0;
        w.cnt    = plads_pkg::CNT_W'(list_len);
        model_words.push_back(w);
      end
      default: begin
        dumps_sent++;
        if (list_len == 0) begin
          w.status = plads_pkg::ST_EMPTY;
          model_words.push_back(w);
        end else begin
          for (i = 0; i < list_len; i++) begin
            w.status = plads_pkg::ST_DUMP;
            w.value  = list_keys[i];
            w.pos    = plads_pkg::POS_W'(i);
            w.cnt    = plads_pkg::CNT_W'(list_len);
            w.last   = (i + 1 == list_len);
            model_words.push_back(w);
          end
        end
      end
    endcase
    if (list_len > list_peak) list_peak = list_len;
  endtask

  // called at a falling edge; returns at the falling edge after the accept
  task automatic send_request(input plads_pkg::req_t kind,
                              input logic [plads_pkg::VAL_W-1:0] key,
                              input bit typed, input list_word_t typed_word);
    while (!steady && $urandom_range(0, 99) < 29) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= kind;
    in_ch.key_value <= key;
    do @(posedge clk); while (!in_ch.ready);
    model_request(kind, key);
    if (typed) pending_words.push_back(typed_word);
    else foreach (model_words[i]) pending_words.push_back(model_words[i]);
    requests_sent++;
    @(negedge clk);
  endtask

  function automatic logic [plads_pkg::VAL_W-1:0] pick_key();
    logic [plads_pkg::VAL_W-1:0] k;
    case ($urandom_range(0, 11))
      0, 1, 2, 3: k = (list_len > 0) ? list_keys[$urandom_range(0, list_len - 1)] : 48'h1;
      4: k = 48'h1;
      5: k = 48'h8000_0000_0000;
      6: k = 48'h1234_5678_9ABC;
      7: k = 48'hFFFF_FFFF_FFFE;
      8: k = $urandom_range(0, 1) ? ALL1 : '0;
      default: k = plads_pkg::VAL_W'({$urandom, $urandom});
    endcase
    return k;
  endfunction

  function automatic plads_pkg::req_t pick_req();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return plads_pkg::REQ_APPEND;
    if (r < 65) return plads_pkg::REQ_DELETE;
    if (r < 90) return plads_pkg::REQ_SEARCH;
    return plads_pkg::REQ_DUMP;
  endfunction

  // receiver
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= hold_off ? 1'b0 : (steady ? 1'b1 : ($urandom_range(0, 99) >= 29));
    end
  end

  // long receiver block once traffic is flowing
  initial begin
    hold_off = 1'b0;
    wait (in_accepts >= 30);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  initial steady = 1'b0;
  always @(posedge clk) steady <= (in_accepts >= 80 && in_accepts < 150);

  always @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) in_accepts <= in_accepts + 1;
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ERROR no word moved for %0d cycles", $time, IDLE_LIMIT);
      $display("** packed_list_add_delete_search_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        report($sformatf("unexpected word status %0d pos %0d", out_ch.status, out_ch.position));
      end else begin
        want = pending_words.pop_front();
        if (out_ch.status !== want.status)
          report($sformatf("word %0d status: got %0d, expected %0d",
                           words_checked, out_ch.status, want.status));
        if (out_ch.entry_value !== want.value)
          report($sformatf("word %0d entry_value: got %0h, expected %0h",
                           words_checked, out_ch.entry_value, want.value));
        if (out_ch.position !== want.pos)
          report($sformatf("word %0d position: got %0d, expected %0d",
                           words_checked, out_ch.position, want.pos));
        if (out_ch.entry_count !== want.cnt)
          report($sformatf("word %0d entry_count: got %0d, expected %0d",
                           words_checked, out_ch.entry_count, want.cnt));
        if (out_ch.last !== want.last)
          report($sformatf("word %0d last: got %0b, expected %0b",
                           words_checked, out_ch.last, want.last));
        words_checked++;
      end
    end
  end

  initial begin
    list_word_t tw;
    int         n;
    in_ch.valid     = 1'b0;
    in_ch.req_type  = plads_pkg::REQ_APPEND;
    in_ch.key_value = '0;
    rst_n           = 1'b0;
    list_len        = 0;
    list_peak       = 0;
    mismatches      = 0;
    words_checked   = 0;
    requests_sent   = 0;
    dumps_sent      = 0;
    full_hits       = 0;
    fills           = 0;
    in_accepts      = 0;
    idle_cycles     = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      tw = '{status: directed_rows[i].status, value: '0, pos: directed_rows[i].pos,
             cnt: directed_rows[i].cnt, last: 1'b1};
      send_request(directed_rows[i].kind, directed_rows[i].key, directed_rows[i].typed, tw);
    end

    tw = '0;
    while (requests_sent < NUM_DIRECTED + RANDOM_REQUESTS) begin
      n = $urandom_range(0, 9);
      if (fills < 3 && (n == 0 || (fills == 0 && requests_sent > NUM_DIRECTED + 100))) begin
        fills++;
        while (list_len < DEPTH) send_request(plads_pkg::REQ_APPEND, pick_key(), 1'b0, tw);
        repeat (2) send_request(plads_pkg::REQ_APPEND, pick_key(), 1'b0, tw);
        send_request(plads_pkg::REQ_SEARCH, pick_key(), 1'b0, tw);
        send_request(plads_pkg::REQ_DUMP, pick_key(), 1'b0, tw);
      end else if (n == 1) begin
        while (list_len > 0)
          send_request(plads_pkg::REQ_DELETE, list_keys[$urandom_range(0, list_len - 1)],
                       1'b0, tw);
        send_request(plads_pkg::REQ_DUMP, pick_key(), 1'b0, tw);
        send_request(plads_pkg::REQ_SEARCH, pick_key(), 1'b0, tw);
      end else begin
        repeat ($urandom_range(5, 20)) send_request(pick_req(), pick_key(), 1'b0, tw);
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d requests (%0d dumps, %0d appends to a full list, %0d fills)",
             requests_sent, dumps_sent, full_hits, fills);
    $display("Checked %0d result words; list peak %0d of %0d entries, %0d errors",
             words_checked, list_peak, DEPTH, mismatches);
    if (mismatches == 0) begin
      $display("** packed_list_add_delete_search_unit: PASSED **");
    end else begin
      $display("** packed_list_add_delete_search_unit: FAILED **");
    end
    $finish;
  end

endmodule
